// ===== src/mx2_pkg.sv =====
// ----------------------------------------------------------------------------
// mx2_pkg
// Shared types and codes for the 2x2 fixed-point matrix unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mx2_pkg;

    localparam int FIELD_W = 32;

    typedef logic signed [FIELD_W-1:0] t_word;

    // Action codes of a request; code 7 behaves like read.
    typedef enum logic [2:0] {
        ACT_LOAD  = 3'd0,
        ACT_DIAG  = 3'd1,
        ACT_ADD   = 3'd2,
        ACT_SCALE = 3'd3,
        ACT_MUL   = 3'd4,
        ACT_INV   = 3'd5,
        ACT_READ  = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DLOAD,
        ST_DRUN,
        ST_OUT
    } t_state;

    // What the product sequence is computing.
    typedef enum logic [1:0] {
        MM_SCALE,
        MM_MATMUL,
        MM_DET
    } t_mmode;

    typedef struct packed {
        t_word val;
        logic  clip;
    } t_sat;

    // Serial divider request and response (unsigned magnitudes).
    typedef struct packed {
        logic                 start;
        logic [63:0]          num;
        logic [FIELD_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== src/mx2_if.sv =====
// ----------------------------------------------------------------------------
// mx2_if
// Request and result channels of the 2x2 matrix unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface mx2_in_if import mx2_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    t_word       op_a;
    t_word       op_b;
    t_word       op_c;
    t_word       op_d;
    logic        column;
    logic        row;

    modport source (output valid, action, op_a, op_b, op_c, op_d, column, row,
                    input ready);
    modport sink   (input valid, action, op_a, op_b, op_c, op_d, column, row,
                    output ready);
endinterface

interface mx2_out_if import mx2_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word top_left;
    t_word top_right;
    t_word bottom_left;
    t_word bottom_right;
    t_word det_value;
    t_word picked_value;
    logic  singular;
    logic  saturated;

    modport source (output valid, top_left, top_right, bottom_left, bottom_right,
                    det_value, picked_value, singular, saturated,
                    input ready);
    modport sink   (input valid, top_left, top_right, bottom_left, bottom_right,
                    det_value, picked_value, singular, saturated,
                    output ready);
endinterface

`default_nettype wire

// ===== src/mx2_div.sv =====
// ----------------------------------------------------------------------------
// mx2_div
// Restoring radix-2 divider, 64-bit by 32-bit unsigned, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mx2_div import mx2_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic [6:0]         r_cnt;
    logic               r_done;
    logic [FIELD_W:0]   r_rem;
    logic [63:0]        r_q;
    logic [FIELD_W-1:0] r_den;

    logic [FIELD_W:0]   rem_sh;
    logic               fits;

    assign rem_sh = {r_rem[FIELD_W-1:0], r_q[63]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 7'd1);
            if (i_req.start) begin
                r_cnt <= 7'd64;
            end else if (r_cnt != 7'd0) begin
                r_cnt <= r_cnt - 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_cnt != 7'd0) begin
            r_rem <= fits ? rem_sh - {1'b0, r_den} : rem_sh;
            r_q   <= {r_q[62:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

`default_nettype wire

// ===== src/matrix2x2_accumulator_alu_unit.sv =====
// ----------------------------------------------------------------------------
// matrix2x2_accumulator_alu_unit
// 2x2 signed fixed-point matrix accumulator with load, diagonal load, add, scale,
// multiply, in-place inverse and element read, all results saturated.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------------------------
//  i_req    | in  | valid/ready   | action, op_a..op_d, column, row
//  o_res    | out | valid/ready   | four elements, det, picked, singular, sat
//
//  Sequence from accept to result: load/diag/add/read run the determinant and
//  the output stage; scale and multiply run their products before the
//  determinant; a singular inverse stops after the determinant check; an inverse
//  runs the check, four serial divisions, a new determinant and the output stage.
//  Products go through a single shared 32x32 multiplier, one per cycle.
//  Reset clears the matrix to zero and empties the output register.
//  i_req is only ready in idle, entered as the result is registered;
//  a stalled result holds the unit in its output stage until o_res takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix2x2_accumulator_alu_unit import mx2_pkg::*; #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mx2_in_if.sink    i_req,
    mx2_out_if.source o_res
);

    // Effective element width and fraction bits (fields are 32 bits wide).
    localparam int WB = (WORD_BITS > FIELD_W) ? FIELD_W : WORD_BITS;
    localparam int FB = (FRAC_BITS > 31) ? 31 : FRAC_BITS;

    localparam logic signed [65:0] SAT_HI = (66'sd1 <<< (WB - 1)) - 66'sd1;
    localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;

    // Product counts per sequence.
    localparam logic [3:0] N_SCALE = 4'd4;
    localparam logic [3:0] N_MAT   = 4'd8;
    localparam logic [3:0] N_DET   = 4'd2;

    // Clip a wide value to the element range.
    function automatic t_sat f_sat(input logic signed [65:0] v);
        t_sat s;
        if (v > SAT_HI) begin
            s.val  = t_word'(SAT_HI);
            s.clip = 1'b1;
        end else if (v < SAT_LO) begin
            s.val  = t_word'(SAT_LO);
            s.clip = 1'b1;
        end else begin
            s.val  = t_word'(v);
            s.clip = 1'b0;
        end
        return s;
    endfunction

    function automatic logic signed [65:0] f_ext(input t_word w);
        return 66'(w);
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    t_mmode              r_mode,  n_mode;
    logic [3:0]          r_k,     n_k;
    logic [1:0]          r_j,     n_j;
    logic                r_pre,   n_pre;
    logic                r_satf,  n_satf;
    logic                r_sing,  n_sing;
    logic                r_neg,   n_neg;
    t_word               r_elem [4];
    t_word               r_nx   [4];
    t_word               n_nx   [4];
    t_word               r_op   [4];
    logic                r_col, r_row;
    t_word               r_det,   n_det;
    logic signed [63:0]  r_prod,  n_prod;
    logic signed [65:0]  r_acc,   n_acc;
    logic                r_ovalid;
    t_word               r_o_el [4];
    t_word               r_o_det, r_o_pick;
    logic                r_o_sing, r_o_sat;

    t_div_req            div_req;
    t_div_rsp            div_rsp;

    mx2_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Combinational sequencer
    // ------------------------------------------------------------------
    t_word              ma, mb;
    logic [3:0]         jk;
    logic [3:0]         n_total;
    logic signed [65:0] p_ext;
    logic signed [65:0] sum;
    t_sat               sres;
    logic signed [32:0] dx;
    logic [32:0]        dx_abs;
    logic signed [65:0] q_s;
    t_word              in_op [4];
    logic               accept;

    assign in_op[0] = i_req.op_a;
    assign in_op[1] = i_req.op_b;
    assign in_op[2] = i_req.op_c;
    assign in_op[3] = i_req.op_d;

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign jk          = r_k - 4'd1;
    assign p_ext       = 66'(r_prod);

    always_comb begin
        case (r_mode)
            MM_SCALE:  n_total = N_SCALE;
            MM_MATMUL: n_total = N_MAT;
            default:   n_total = N_DET;
        endcase
    end

    // Multiplier operand select for product r_k.
    always_comb begin
        case (r_mode)
            MM_SCALE: begin
                ma = r_elem[r_k[1:0]];
                mb = r_op[0];
            end
            MM_MATMUL: begin
                // row r_k[2], column r_k[1], second term r_k[0]
                ma = r_elem[{r_k[2], r_k[0]}];
                mb = r_op[{r_k[0], r_k[1]}];
            end
            default: begin
                ma = r_k[0] ? r_nx[1] : r_nx[0];
                mb = r_k[0] ? r_nx[2] : r_nx[3];
            end
        endcase
    end

    // Divider source element: [d -b; -c a].
    always_comb begin
        case (r_j)
            2'd0:    dx = 33'(r_elem[3]);
            2'd1:    dx = -33'(r_elem[1]);
            2'd2:    dx = -33'(r_elem[2]);
            default: dx = 33'(r_elem[0]);
        endcase
        dx_abs = dx[32] ? 33'(-dx) : 33'(dx);
    end

    assign q_s = r_neg ? -$signed({2'b00, div_rsp.quot}) : $signed({2'b00, div_rsp.quot});

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_k     = r_k;
        n_j     = r_j;
        n_pre   = r_pre;
        n_satf  = r_satf;
        n_sing  = r_sing;
        n_neg   = r_neg;
        n_det   = r_det;
        n_acc   = r_acc;
        n_prod  = r_prod;
        n_nx    = r_nx;
        sum     = '0;
        sres    = '0;
        div_req = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_satf  = 1'b0;
                    n_sing  = 1'b0;
                    n_k     = '0;
                    n_pre   = 1'b0;
                    n_mode  = MM_DET;
                    n_state = ST_MUL;
                    n_nx    = r_elem;
                    case (i_req.action)
                        ACT_LOAD: begin
                            for (int i = 0; i < 4; i++) begin
                                sres     = f_sat(f_ext(in_op[i]));
                                n_nx[i]  = sres.val;
                                n_satf   = n_satf | sres.clip;
                            end
                        end
                        ACT_DIAG: begin
                            sres    = f_sat(f_ext(in_op[0]));
                            n_nx[0] = sres.val;
                            n_nx[3] = sres.val;
                            n_nx[1] = '0;
                            n_nx[2] = '0;
                            n_satf  = sres.clip;
                        end
                        ACT_ADD: begin
                            for (int i = 0; i < 4; i++) begin
                                sres    = f_sat(f_ext(r_elem[i]) + f_ext(in_op[i]));
                                n_nx[i] = sres.val;
                                n_satf  = n_satf | sres.clip;
                            end
                        end
                        ACT_SCALE: n_mode = MM_SCALE;
                        ACT_MUL:   n_mode = MM_MATMUL;
                        ACT_INV:   n_pre  = 1'b1;
                        default: ;
                    endcase
                end
            end

            ST_MUL: begin
                if (r_k < n_total) begin
                    n_prod = ma * mb;
                end
                if (r_k != 4'd0) begin
                    case (r_mode)
                        MM_SCALE: begin
                            sres            = f_sat(p_ext >>> FB);
                            n_nx[jk[1:0]]   = sres.val;
                            n_satf          = r_satf | sres.clip;
                        end
                        MM_MATMUL: begin
                            if (!jk[0]) begin
                                n_acc = p_ext;
                            end else begin
                                sum           = r_acc + p_ext;
                                sres          = f_sat(sum >>> FB);
                                n_nx[jk[2:1]] = sres.val;
                                n_satf        = r_satf | sres.clip;
                            end
                        end
                        default: begin
                            if (!jk[0]) begin
                                n_acc = p_ext;
                            end else begin
                                sum   = r_acc - p_ext;
                                sres  = f_sat(sum >>> FB);
                                n_det = sres.val;
                            end
                        end
                    endcase
                end
                n_k = r_k + 4'd1;
                if (r_k == n_total) begin
                    n_k = '0;
                    if (r_mode != MM_DET) begin
                        n_mode = MM_DET;
                    end else if (r_pre) begin
                        // inverse: pre-check determinant, its clip is dropped
                        n_pre = 1'b0;
                        if (sres.val == '0) begin
                            n_sing  = 1'b1;
                            n_state = ST_OUT;
                        end else begin
                            n_j     = '0;
                            n_state = ST_DLOAD;
                        end
                    end else begin
                        n_satf  = r_satf | sres.clip;
                        n_state = ST_OUT;
                    end
                end
            end

            ST_DLOAD: begin
                div_req.start = 1'b1;
                div_req.num   = {31'b0, dx_abs} << FB;
                div_req.den   = r_det[FIELD_W-1] ? FIELD_W'(-r_det) : FIELD_W'(r_det);
                n_neg         = dx[32] ^ r_det[FIELD_W-1];
                n_state       = ST_DRUN;
            end

            ST_DRUN: begin
                if (div_rsp.done) begin
                    sres       = f_sat(q_s);
                    n_nx[r_j]  = sres.val;
                    n_satf     = r_satf | sres.clip;
                    n_j        = r_j + 2'd1;
                    if (r_j == 2'd3) begin
                        n_mode  = MM_DET;
                        n_k     = '0;
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_DLOAD;
                    end
                end
            end

            ST_OUT: begin
                if (!r_ovalid || o_res.ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // State and datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_k    <= n_k;
        r_j    <= n_j;
        r_pre  <= n_pre;
        r_satf <= n_satf;
        r_sing <= n_sing;
        r_neg  <= n_neg;
        r_det  <= n_det;
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_nx   <= n_nx;
        if (accept) begin
            r_op  <= in_op;
            r_col <= i_req.column;
            r_row <= i_req.row;
        end
    end

    // Matrix store, committed when the result leaves for the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_elem[i] <= '0;
            end
        end else if (r_state == ST_OUT && (!r_ovalid || o_res.ready)) begin
            r_elem <= r_nx;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_OUT && (!r_ovalid || o_res.ready)) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && (!r_ovalid || o_res.ready)) begin
            r_o_el   <= r_nx;
            r_o_det  <= r_det;
            r_o_pick <= r_nx[{r_row, r_col}];
            r_o_sing <= r_sing;
            r_o_sat  <= r_satf;
        end
    end

    assign o_res.valid        = r_ovalid;
    assign o_res.top_left     = r_o_el[0];
    assign o_res.top_right    = r_o_el[1];
    assign o_res.bottom_left  = r_o_el[2];
    assign o_res.bottom_right = r_o_el[3];
    assign o_res.det_value    = r_o_det;
    assign o_res.picked_value = r_o_pick;
    assign o_res.singular     = r_o_sing;
    assign o_res.saturated    = r_o_sat;

endmodule

`default_nettype wire
